// ===== rtl/core/cwg_pkg.sv =====
// Shared types and constants for the count window gate.
// Holds operation, phase, status and register codes plus the item records
// passed between the front end, the queue and the back end.
package cwg_pkg;

	// Operation codes carried in the input tuser
	localparam logic [2:0] OP_START = 3'd0;
	localparam logic [2:0] OP_STOP  = 3'd1;
	localparam logic [2:0] OP_DONE  = 3'd2;
	localparam logic [2:0] OP_DET   = 3'd3;
	localparam logic [2:0] OP_MON   = 3'd4;
	localparam logic [2:0] OP_FORCE = 3'd5;

	// Window phases
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_COUNT = 2'd1;
	localparam logic [1:0] PH_WAIT  = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_IGNORED  = 2'd1;
	localparam logic [1:0] ST_RESTART  = 2'd2;
	localparam logic [1:0] ST_STRAY    = 2'd3;

	// Elapsed register action handed down the back pipeline
	localparam logic [1:0] EL_KEEP  = 2'd0;
	localparam logic [1:0] EL_CLEAR = 2'd1;
	localparam logic [1:0] EL_LOAD  = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TSEC  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TNSEC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO  = 2'd2;

	// Time constants
	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
	localparam logic [30:0] NS_TWO_SEC = 31'd2000000000;

	// Divide by 1e9: drop 9 low bits (1e9 = 2^9 * 1953125), then multiply
	// by ceil(2^52 / 1953125) and shift by 52. Exact for operands below 2^31.
	localparam int NS_SHIFT = 9;
	localparam logic [31:0] RECIP_M = 32'd2305843010;
	localparam int RECIP_SHIFT = 52;

	// Pipeline depths
	localparam int FRONT_STAGES = 4;
	localparam int BACK_STAGES  = 2;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [31:0] timeout_sec;
		logic [29:0] timeout_nsec;
		logic        restart_en;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] pulse;
		logic [31:0] flight;
		logic [31:0] delta;
		logic [1:0]  forced;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] delta;
		logic [1:0]  forced;
	} ctx_t;

	typedef struct packed {
		ctx_t        ctx;
		logic [31:0] sec;
		logic [29:0] nsec;
		logic [32:0] dl_sec;
		logic [29:0] dl_nsec;
	} fr_item_t;

	typedef struct packed {
		logic [1:0]         phase;
		logic [1:0]         status;
		logic               publish;
		logic [31:0]        det;
		logic [31:0]        mon;
		logic [32:0]        dl_sec;
		logic [29:0]        dl_nsec;
		logic [1:0]         eact;
		logic signed [32:0] ds;
		logic signed [30:0] dn;
	} bk_s2_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic [1:0]  status;
		logic        publish;
		logic [31:0] det;
		logic [31:0] mon;
		logic [63:0] elapsed;
		logic [32:0] dl_sec;
		logic [29:0] dl_nsec;
	} res_t;

endpackage

// ===== rtl/core/cwg_front.sv =====
// Front end of the count window gate: event time and done deadline.
// Four-stage pipeline, independent of window state; depends on cwg_pkg.
module cwg_front #(
	parameter int FLIGHT_BITS = 21
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cwg_pkg::in_item_t in_item,
	input  logic              in_valid,
	output logic              in_ready,
	input  cwg_pkg::cfg_t     cfg,
	output cwg_pkg::fr_item_t out_item,
	output logic              out_valid,
	input  logic              out_ready
);
	import cwg_pkg::*;

	localparam int PROD_W = FLIGHT_BITS + 7;
	localparam int SUM_W  = ((PROD_W > 32) ? PROD_W : 32) + 1;
	localparam int T_W    = SUM_W - NS_SHIFT;
	localparam int Q_W    = SUM_W - 29;
	localparam int MUL_W  = T_W + 32;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	ctx_t             ctx_s1, ctx_s2, ctx_s3;
	logic [31:0]      sec_s1, sec_s2, sec_s3;
	logic [SUM_W-1:0] sum_s1, sum_s2;
	logic [Q_W-1:0]   q_s2;
	logic [29:0]      nsec_s3;
	fr_item_t         item_s4;

	logic [SUM_W-1:0] sum_in;
	logic [MUL_W-1:0] q_prod;
	logic [SUM_W-1:0] q_ns;
	logic [30:0]      dsum;
	logic [1:0]       dq;
	logic [29:0]      dl_nsec;

	// Stage handshakes: a stage loads when empty or when it drains forward
	assign adv4 = !v_s4 || out_ready;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	// Stage 1: pulse nanoseconds plus masked flight time in nanoseconds
	assign sum_in = SUM_W'(in_item.pulse[31:0])
		+ SUM_W'(in_item.flight[FLIGHT_BITS-1:0]) * SUM_W'(100);

	// Stage 2: whole seconds in the nanosecond sum by reciprocal multiply
	assign q_prod = MUL_W'(sum_s1[SUM_W-1:NS_SHIFT]) * MUL_W'(RECIP_M);

	// Stage 3: remainder and carried seconds
	assign q_ns = SUM_W'(q_s2) * SUM_W'(NS_PER_SEC);

	// Stage 4: add timeout, carry at most two seconds
	always_comb begin
		dsum = 31'(nsec_s3) + 31'(cfg.timeout_nsec);
		if (dsum >= NS_TWO_SEC) begin
			dq = 2'd2;
			dl_nsec = 30'(dsum - NS_TWO_SEC);
		end else if (dsum >= 31'(NS_PER_SEC)) begin
			dq = 2'd1;
			dl_nsec = 30'(dsum - 31'(NS_PER_SEC));
		end else begin
			dq = 2'd0;
			dl_nsec = 30'(dsum);
		end
	end

	// Advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (adv1) begin
			ctx_s1 <= '{op: in_item.op, delta: in_item.delta, forced: in_item.forced};
			sec_s1 <= in_item.pulse[63:32];
			sum_s1 <= sum_in;
		end
		if (adv2) begin
			ctx_s2 <= ctx_s1;
			sec_s2 <= sec_s1;
			sum_s2 <= sum_s1;
			q_s2   <= q_prod[RECIP_SHIFT +: Q_W];
		end
		if (adv3) begin
			ctx_s3  <= ctx_s2;
			sec_s3  <= sec_s2 + 32'(q_s2);
			nsec_s3 <= 30'(sum_s2 - q_ns);
		end
		if (adv4) begin
			item_s4.ctx     <= ctx_s3;
			item_s4.sec     <= sec_s3;
			item_s4.nsec    <= nsec_s3;
			item_s4.dl_sec  <= 33'(sec_s3) + 33'(cfg.timeout_sec) + 33'(dq);
			item_s4.dl_nsec <= dl_nsec;
		end
	end

	assign out_item  = item_s4;
	assign out_valid = v_s4;

endmodule

// ===== rtl/core/cwg_queue.sv =====
// Short queue between the front end and the back end of the window gate.
// Register array with read and write pointers; depends on cwg_pkg.
module cwg_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  cwg_pkg::fr_item_t wr_item,
	input  logic              wr_valid,
	output logic              wr_ready,
	output cwg_pkg::fr_item_t rd_item,
	output logic              rd_valid,
	input  logic              rd_ready
);
	import cwg_pkg::*;

	fr_item_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push, pop;

	assign wr_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;
	assign rd_item = mem_q[rptr_q];

	// Move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + QPTR_W'(1);
			if (pop) rptr_q <= rptr_q + QPTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	// Store an item
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wr_item;
	end

endmodule

// ===== rtl/core/cwg_back.sv =====
// Back end of the window gate: phase machine, accumulators, elapsed time.
// Applies one queued item per cycle while the output is not stalled, then an output register; uses cwg_pkg.
module cwg_back #(
	parameter int PUBLISH_INTERVAL = 100
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cwg_pkg::cfg_t     cfg,
	input  cwg_pkg::fr_item_t in_item,
	input  logic              in_valid,
	output logic              in_ready,
	output cwg_pkg::res_t     res,
	output logic              res_valid,
	input  logic              res_ready
);
	import cwg_pkg::*;

	localparam int PUB_W = $clog2(PUBLISH_INTERVAL + 1);

	// Window state
	logic [1:0]       phase_q;
	logic [31:0]      start_sec_q;
	logic [29:0]      start_ns_q;
	logic [32:0]      dl_sec_q;
	logic [29:0]      dl_nsec_q;
	logic [31:0]      det_q, mon_q;
	logic [PUB_W-1:0] det_pub_q, mon_pub_q;
	logic [63:0]      elapsed_q;

	logic [1:0]       n_phase;
	logic [31:0]      n_start_sec;
	logic [29:0]      n_start_ns;
	logic [31:0]      n_det, n_mon;
	logic [PUB_W-1:0] n_det_pub, n_mon_pub;
	logic [PUB_W-1:0] det_pub_inc, mon_pub_inc;
	bk_s2_t           n_s2;

	bk_s2_t             item_s2;
	logic               v_s2;
	res_t               res_s3;
	logic               v_s3;
	logic               adv2, adv3, fire;
	logic signed [62:0] el_prod;
	logic [63:0]        el_next;

	assign adv3 = !v_s3 || res_ready;
	assign adv2 = !v_s2 || adv3;
	assign in_ready = adv2;
	assign fire = in_valid && adv2;

	assign det_pub_inc = det_pub_q + PUB_W'(1);
	assign mon_pub_inc = mon_pub_q + PUB_W'(1);

	// Apply one item to the window state
	always_comb begin
		n_phase     = phase_q;
		n_start_sec = start_sec_q;
		n_start_ns  = start_ns_q;
		n_det       = det_q;
		n_mon       = mon_q;
		n_det_pub   = det_pub_q;
		n_mon_pub   = mon_pub_q;
		n_s2.status  = ST_IGNORED;
		n_s2.publish = 1'b0;
		n_s2.dl_sec  = dl_sec_q;
		n_s2.dl_nsec = dl_nsec_q;
		n_s2.eact    = EL_KEEP;
		n_s2.ds = $signed({1'b0, in_item.sec}) - $signed({1'b0, start_sec_q});
		n_s2.dn = $signed({1'b0, in_item.nsec}) - $signed({1'b0, start_ns_q});
		case (in_item.ctx.op)
			OP_START: begin
				if (phase_q == PH_IDLE) begin
					n_s2.status = ST_ACCEPTED;
				end else if (phase_q == PH_COUNT
					|| (phase_q == PH_DONE && cfg.restart_en)) begin
					n_s2.status = ST_RESTART;
				end
				if (n_s2.status != ST_IGNORED) begin
					n_start_sec  = in_item.sec;
					n_start_ns   = in_item.nsec;
					n_s2.dl_sec  = '0;
					n_s2.dl_nsec = '0;
					n_s2.eact    = EL_CLEAR;
					n_det        = '0;
					n_mon        = '0;
					n_det_pub    = '0;
					n_mon_pub    = '0;
					n_phase      = PH_COUNT;
					n_s2.publish = 1'b1;
				end
			end
			OP_STOP: begin
				n_s2.publish = 1'b1;
				if (phase_q != PH_COUNT) begin
					// Stray stop wipes the statistics, phase stays
					n_start_sec  = '0;
					n_start_ns   = '0;
					n_s2.dl_sec  = '0;
					n_s2.dl_nsec = '0;
					n_s2.eact    = EL_CLEAR;
					n_det        = '0;
					n_mon        = '0;
					n_det_pub    = '0;
					n_mon_pub    = '0;
					n_s2.status  = ST_STRAY;
				end else begin
					n_s2.eact    = EL_LOAD;
					n_s2.dl_sec  = in_item.dl_sec;
					n_s2.dl_nsec = in_item.dl_nsec;
					n_phase      = PH_WAIT;
					n_s2.status  = ST_ACCEPTED;
				end
			end
			OP_DONE: begin
				if (phase_q == PH_WAIT) begin
					n_phase      = PH_DONE;
					n_s2.status  = ST_ACCEPTED;
					n_s2.publish = 1'b1;
				end
			end
			OP_DET: begin
				if (phase_q == PH_COUNT || phase_q == PH_WAIT) begin
					n_det        = det_q + in_item.ctx.delta;
					n_s2.publish = (det_pub_q == '0);
					n_det_pub    = (det_pub_inc >= PUB_W'(PUBLISH_INTERVAL)) ? '0 : det_pub_inc;
					n_s2.status  = ST_ACCEPTED;
				end
			end
			OP_MON: begin
				if (phase_q == PH_COUNT || phase_q == PH_WAIT) begin
					n_mon        = mon_q + in_item.ctx.delta;
					n_s2.publish = (mon_pub_q == '0);
					n_mon_pub    = (mon_pub_inc >= PUB_W'(PUBLISH_INTERVAL)) ? '0 : mon_pub_inc;
					n_s2.status  = ST_ACCEPTED;
				end
			end
			OP_FORCE: begin
				n_phase     = in_item.ctx.forced;
				n_s2.status = ST_ACCEPTED;
			end
			default: begin
			end
		endcase
		n_s2.phase = n_phase;
		n_s2.det   = n_det;
		n_s2.mon   = n_mon;
	end

	// Hold window state, update on each applied item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			start_sec_q <= '0;
			start_ns_q  <= '0;
			dl_sec_q    <= '0;
			dl_nsec_q   <= '0;
			det_q       <= '0;
			mon_q       <= '0;
			det_pub_q   <= '0;
			mon_pub_q   <= '0;
		end else if (fire) begin
			phase_q     <= n_phase;
			start_sec_q <= n_start_sec;
			start_ns_q  <= n_start_ns;
			dl_sec_q    <= n_s2.dl_sec;
			dl_nsec_q   <= n_s2.dl_nsec;
			det_q       <= n_det;
			mon_q       <= n_mon;
			det_pub_q   <= n_det_pub;
			mon_pub_q   <= n_mon_pub;
		end
	end

	// Elapsed nanoseconds: signed seconds difference scaled plus nanosecond difference
	assign el_prod = 63'(item_s2.ds) * 63'(NS_PER_SEC);
	always_comb begin
		case (item_s2.eact)
			EL_LOAD:  el_next = 64'(el_prod) + 64'(item_s2.dn);
			EL_CLEAR: el_next = '0;
			default:  el_next = elapsed_q;
		endcase
	end

	// Advance valid flags and elapsed state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			elapsed_q <= '0;
		end else begin
			if (adv2) v_s2 <= in_valid;
			if (adv3) begin
				v_s3 <= v_s2;
				if (v_s2) elapsed_q <= el_next;
			end
		end
	end

	// Advance payload to the output register
	always_ff @(posedge clk) begin
		if (fire) item_s2 <= n_s2;
		if (adv3) begin
			res_s3.phase   <= item_s2.phase;
			res_s3.status  <= item_s2.status;
			res_s3.publish <= item_s2.publish;
			res_s3.det     <= item_s2.det;
			res_s3.mon     <= item_s2.mon;
			res_s3.elapsed <= el_next;
			res_s3.dl_sec  <= item_s2.dl_sec;
			res_s3.dl_nsec <= item_s2.dl_nsec;
		end
	end

	assign res = res_s3;
	assign res_valid = v_s3;

endmodule

// ===== rtl/core/count_window_gate.sv =====
// Top level of the count window gate: ports, configuration registers, checks.
// Instantiates cwg_front, cwg_queue and cwg_back; depends on cwg_pkg.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------------
//   s_*      | s_tvalid/s_tready  | s_tuser operation, s_tdata event fields
//   m_*      | m_tvalid/m_tready  | m_tdata result fields
//   cfg_*    | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// One item per cycle sustained while m_tready stays high; a result passes
// through four front stages (event time carry by reciprocal
// multiply, deadline carry), one queue slot, the state update and the
// elapsed-time multiply ahead of the output register.
// Reset clears the window state, the statistics and all three registers.
// Either side may stall on its own; the queue absorbs front results while
// the output waits, and s_tready drops only when the queue is full.
module count_window_gate #(
	parameter int PUBLISH_INTERVAL = 100,
	parameter int FLIGHT_BITS = 21
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// bits: pulse_time[63:0], flight_time[95:64], count_delta[127:96],
	// forced_phase[129:128], zero fill [135:130]
	input  logic [135:0]                 s_tdata,
	// bits: operation[2:0]
	input  logic [2:0]                   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// bits: phase[1:0], status[3:2], publish[4], detector_total[36:5],
	// monitor_total[68:37], elapsed_ns[132:69], deadline_sec[165:133],
	// deadline_nsec[195:166], zero fill [199:196]
	output logic [199:0]                 m_tdata,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [cwg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                  cfg_data
);
	import cwg_pkg::*;

	localparam int INFLIGHT_MAX = FRONT_STAGES + QDEPTH + BACK_STAGES;
	localparam int INFLIGHT_W = $clog2(INFLIGHT_MAX + 1);

	cfg_t     cfg_q;
	in_item_t in_item;
	fr_item_t fr_item, q_item;
	logic     fr_valid, fr_ready, q_valid, q_ready;
	res_t     res;

	logic [INFLIGHT_W-1:0] inflight_q;
	logic                  s_fire, m_fire;

	// Store configuration writes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TSEC:  cfg_q.timeout_sec  <= cfg_data;
				CFG_TNSEC: cfg_q.timeout_nsec <= cfg_data[29:0];
				CFG_AUTO:  cfg_q.restart_en   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Unpack the input item
	assign in_item.op     = s_tuser;
	assign in_item.pulse  = s_tdata[63:0];
	assign in_item.flight = s_tdata[95:64];
	assign in_item.delta  = s_tdata[127:96];
	assign in_item.forced = s_tdata[129:128];

	cwg_front #(
		.FLIGHT_BITS(FLIGHT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cfg      (cfg_q),
		.out_item (fr_item),
		.out_valid(fr_valid),
		.out_ready(fr_ready)
	);

	cwg_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_item (fr_item),
		.wr_valid(fr_valid),
		.wr_ready(fr_ready),
		.rd_item (q_item),
		.rd_valid(q_valid),
		.rd_ready(q_ready)
	);

	cwg_back #(
		.PUBLISH_INTERVAL(PUBLISH_INTERVAL)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_item  (q_item),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.res      (res),
		.res_valid(m_tvalid),
		.res_ready(m_tready)
	);

	// Pack the result item
	assign m_tdata = {4'b0, res.dl_nsec, res.dl_sec, res.elapsed, res.mon, res.det,
		res.publish, res.status, res.phase};

	// Track items between input and output
	assign s_fire = s_tvalid && s_tready;
	assign m_fire = m_tvalid && m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (s_fire && !m_fire) begin
			inflight_q <= inflight_q + INFLIGHT_W'(1);
		end else if (m_fire && !s_fire) begin
			inflight_q <= inflight_q - INFLIGHT_W'(1);
		end
	end

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= INFLIGHT_W'(INFLIGHT_MAX))
		else $error("more items in flight than pipeline capacity");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != '0)
		else $error("result shown with no item in flight");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.status == ST_RESTART) |->
		(res.phase == PH_COUNT && res.publish && res.det == '0 && res.mon == '0
		&& res.elapsed == '0))
		else $error("restart result without cleared statistics");

	a_ignored_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.status == ST_IGNORED) |-> !res.publish)
		else $error("ignored item raised publish");

endmodule

// ===== verif/tb_count_window_gate.sv =====
// Self-checking bench for count_window_gate: stream items in, results out, registers via cfg.
// Depends on cwg_pkg for codes and the input record; keeps its own model of the window.
// Runs a directed opening, then random count windows under several timeout settings.
module tb_count_window_gate;
	import cwg_pkg::*;

	localparam int PUBLISH_INTERVAL = 100;
	localparam int FLIGHT_BITS = 21;
	localparam logic [63:0] NS_SEC = 64'd1000000000;
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int DRAIN_CYCLES = 24;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1850;
	localparam int MAX_REPORTS = 10;

	// Model of the window: state, registers and the queue of predicted results
	class window_scoreboard;
		logic [31:0] tmo_sec;
		logic [29:0] tmo_nsec;
		logic        auto_rst;
		logic [1:0]  phase;
		logic [31:0] start_sec;
		logic [29:0] start_nsec;
		logic [63:0] elapsed;
		logic [32:0] dl_sec;
		logic [29:0] dl_nsec;
		logic [31:0] det_sum;
		logic [31:0] mon_sum;
		logic [6:0]  det_pub;
		logic [6:0]  mon_pub;
		res_t        predicted_outcomes[$];
		int          mismatches;

		function new();
			tmo_sec = '0;
			tmo_nsec = '0;
			auto_rst = 1'b0;
			phase = PH_IDLE;
			mismatches = 0;
			clear_stats();
		endfunction

		function void clear_stats();
			start_sec = '0;
			start_nsec = '0;
			elapsed = '0;
			dl_sec = '0;
			dl_nsec = '0;
			det_sum = '0;
			mon_sum = '0;
			det_pub = '0;
			mon_pub = '0;
		endfunction

		function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				CFG_TSEC:  tmo_sec = data;
				CFG_TNSEC: tmo_nsec = data[29:0];
				CFG_AUTO:  auto_rst = data[0];
				default: ;
			endcase
		endfunction

		// Pulse time plus masked flight time, with the nanoseconds carried into seconds
		function void event_time(in_item_t ev, output logic [31:0] sec, output logic [29:0] nsec);
			logic [63:0] sum;
			sum = {32'd0, ev.pulse[31:0]} + 64'(ev.flight[FLIGHT_BITS-1:0]) * 64'd100;
			sec = ev.pulse[63:32] + 32'(sum / NS_SEC);
			nsec = 30'(sum % NS_SEC);
		endfunction

		// Apply one accepted item and queue the result it causes
		function void accept_event(in_item_t ev);
			res_t        r;
			logic [31:0] sec;
			logic [29:0] nsec;
			logic [63:0] dsum;
			logic [1:0]  status;
			logic        publish;
			status = ST_IGNORED;
			publish = 1'b0;
			case (ev.op)
				OP_START: begin
					if (phase == PH_IDLE)
						status = ST_ACCEPTED;
					else if (phase == PH_COUNT || (phase == PH_DONE && auto_rst))
						status = ST_RESTART;
					if (status != ST_IGNORED) begin
						event_time(ev, sec, nsec);
						clear_stats();
						start_sec = sec;
						start_nsec = nsec;
						phase = PH_COUNT;
						publish = 1'b1;
					end
				end
				OP_STOP: begin
					publish = 1'b1;
					if (phase != PH_COUNT) begin
						clear_stats();
						status = ST_STRAY;
					end else begin
						event_time(ev, sec, nsec);
						elapsed = (longint'({32'd0, sec}) - longint'({32'd0, start_sec}))
							* longint'(NS_SEC)
							+ (longint'({34'd0, nsec}) - longint'({34'd0, start_nsec}));
						dsum = 64'(nsec) + 64'(tmo_nsec);
						dl_sec = 33'(64'(sec) + 64'(tmo_sec) + dsum / NS_SEC);
						dl_nsec = 30'(dsum % NS_SEC);
						phase = PH_WAIT;
						status = ST_ACCEPTED;
					end
				end
				OP_DONE: begin
					if (phase == PH_WAIT) begin
						phase = PH_DONE;
						status = ST_ACCEPTED;
						publish = 1'b1;
					end
				end
				OP_DET: begin
					if (phase == PH_COUNT || phase == PH_WAIT) begin
						det_sum = det_sum + ev.delta;
						publish = (det_pub == 0);
						det_pub = (det_pub + 1 >= PUBLISH_INTERVAL) ? 7'd0 : 7'(det_pub + 1);
						status = ST_ACCEPTED;
					end
				end
				OP_MON: begin
					if (phase == PH_COUNT || phase == PH_WAIT) begin
						mon_sum = mon_sum + ev.delta;
						publish = (mon_pub == 0);
						mon_pub = (mon_pub + 1 >= PUBLISH_INTERVAL) ? 7'd0 : 7'(mon_pub + 1);
						status = ST_ACCEPTED;
					end
				end
				OP_FORCE: begin
					phase = ev.forced;
					status = ST_ACCEPTED;
				end
				default: ;
			endcase
			r.phase = phase;
			r.status = status;
			r.publish = publish;
			r.det = det_sum;
			r.mon = mon_sum;
			r.elapsed = elapsed;
			r.dl_sec = dl_sec;
			r.dl_nsec = dl_nsec;
			predicted_outcomes.push_back(r);
		endfunction

		function void field_check(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				if (mismatches < MAX_REPORTS)
					$display("mismatch %s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		// Compare one output item with the oldest prediction
		function void check_result(res_t got);
			res_t want;
			if (predicted_outcomes.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected result item %0h", got);
				mismatches++;
				return;
			end
			want = predicted_outcomes.pop_front();
			field_check("phase", 64'(want.phase), 64'(got.phase));
			field_check("status", 64'(want.status), 64'(got.status));
			field_check("publish", 64'(want.publish), 64'(got.publish));
			field_check("detector_total", 64'(want.det), 64'(got.det));
			field_check("monitor_total", 64'(want.mon), 64'(got.mon));
			field_check("elapsed_ns", want.elapsed, got.elapsed);
			field_check("deadline_sec", 64'(want.dl_sec), 64'(got.dl_sec));
			field_check("deadline_nsec", 64'(want.dl_nsec), 64'(got.dl_nsec));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [135:0]         s_tdata;
	logic [2:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [199:0]         m_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	window_scoreboard sb;
	logic             steady = 1'b0;
	int               items_sent = 0;
	logic [31:0]      window_sec = '0;

	count_window_gate #(
		.PUBLISH_INTERVAL(PUBLISH_INTERVAL),
		.FLIGHT_BITS(FLIGHT_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Stall the result side at random, except during the steady stretch
	always @(negedge clk) begin
		m_tready = steady ? 1'b1 : ($urandom_range(99) >= 30);
	end

	// Check every accepted result item
	always @(posedge clk) begin
		res_t r;
		if (arst_n && m_tvalid && m_tready) begin
			r.phase = m_tdata[1:0];
			r.status = m_tdata[3:2];
			r.publish = m_tdata[4];
			r.det = m_tdata[36:5];
			r.mon = m_tdata[68:37];
			r.elapsed = m_tdata[132:69];
			r.dl_sec = m_tdata[165:133];
			r.dl_nsec = m_tdata[195:166];
			sb.check_result(r);
		end
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	function automatic in_item_t mk(logic [2:0] op, logic [63:0] pulse, logic [31:0] flight,
			logic [31:0] delta, logic [1:0] forced);
		in_item_t ev;
		ev.op = op;
		ev.pulse = pulse;
		ev.flight = flight;
		ev.delta = delta;
		ev.forced = forced;
		return ev;
	endfunction

	// Random content; seconds mostly near the current window so elapsed stays sane
	function automatic in_item_t rand_event(logic [2:0] op);
		logic [31:0] secs;
		logic [31:0] nanos;
		secs = ($urandom_range(3) == 0) ? $urandom : window_sec + $urandom_range(0, 3);
		nanos = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(999999999));
		return mk(op, {secs, nanos},
			$urandom_range(1) ? $urandom : 32'($urandom_range(2097151)),
			$urandom_range(1) ? $urandom : 32'($urandom_range(50)),
			2'($urandom_range(3)));
	endfunction

	// Offer one item, with random gaps ahead of it, and hold until accepted
	task automatic send(in_item_t ev);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 30) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {6'd0, ev.forced, ev.delta, ev.flight, ev.pulse};
		s_tuser = ev.op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.accept_event(ev);
		items_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.apply_register(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Stop offering items and wait for the block to empty out
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.predicted_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_count(logic [2:0] favored);
		logic [2:0] op;
		if ($urandom_range(19) == 0)
			op = 3'($urandom_range(7));
		else if ($urandom_range(3) != 0)
			op = favored;
		else
			op = (favored == OP_DET) ? OP_MON : OP_DET;
		send(rand_event(op));
	endtask

	// One well-formed count window with random content and the odd stray item
	task automatic run_window();
		int         n;
		logic [2:0] favored;
		window_sec = $urandom;
		favored = $urandom_range(1) ? OP_DET : OP_MON;
		send(rand_event(OP_START));
		if ($urandom_range(7) == 0)
			send(rand_event(OP_START));
		n = ($urandom_range(7) == 0) ? $urandom_range(140, 260) : $urandom_range(0, 10);
		repeat (n) send_count(favored);
		if ($urandom_range(9) != 0)
			send(rand_event(OP_STOP));
		repeat ($urandom_range(0, 4)) send_count(favored);
		if ($urandom_range(7) != 0)
			send(rand_event(OP_DONE));
		case ($urandom_range(5))
			0: send(rand_event(OP_STOP));
			1: send(rand_event(OP_START));
			2: send(rand_event(OP_FORCE));
			default: ;
		endcase
	endtask

	task automatic random_phase(int count);
		int target;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(4) == 0) begin
				window_sec = $urandom;
				repeat ($urandom_range(1, 6)) send(rand_event(3'($urandom_range(7))));
			end else begin
				run_window();
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_START;
		cfg_valid = 1'b0;
		cfg_index = CFG_TSEC;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Stray and ignored items while idle, unused operation codes
		send(mk(OP_DONE, '0, '0, '0, 2'd0));
		send(mk(OP_DET, '0, '0, 32'hffffffff, 2'd0));
		send(mk(OP_MON, '0, '0, 32'hffffffff, 2'd0));
		send(mk(OP_STOP, '1, '1, '0, 2'd0));
		send(mk(OP_SPARE_LO, '1, '1, '1, 2'd3));
		send(mk(OP_SPARE_HI, '0, '0, '0, 2'd0));
		// Start with nanosecond overflow and seconds wrap, then sums that wrap
		send(mk(OP_START, '1, '1, '0, 2'd0));
		send(mk(OP_DET, '0, '0, 32'hffffffff, 2'd0));
		send(mk(OP_DET, '0, '0, 32'd2, 2'd0));
		send(mk(OP_MON, '0, '0, 32'hffffffff, 2'd0));
		// Restart while counting, then a stop earlier than the start
		send(mk(OP_START, {32'd100, 32'd500}, '0, '0, 2'd0));
		send(mk(OP_STOP, {32'd99, 32'd0}, 32'd7, '0, 2'd0));
		send(mk(OP_START, '0, '0, '0, 2'd0));
		send(mk(OP_DET, '0, '0, 32'd5, 2'd0));
		send(mk(OP_DONE, '0, '0, '0, 2'd0));
		// Done phase without auto reset
		send(mk(OP_START, '0, '0, '0, 2'd0));
		send(mk(OP_DONE, '0, '0, '0, 2'd0));
		send(mk(OP_MON, '0, '0, 32'd1, 2'd0));
		send(mk(OP_STOP, '0, '0, '0, 2'd0));
		// Forced phases
		send(mk(OP_FORCE, '0, '0, '0, PH_DONE));
		send(mk(OP_FORCE, '0, '0, '0, PH_IDLE));
		send(mk(OP_FORCE, '0, '0, '0, PH_COUNT));
		send(mk(OP_FORCE, '0, '0, '0, PH_WAIT));
		send(mk(OP_DONE, '0, '0, '0, 2'd0));
		settle();

		// Largest timeout, nanoseconds past one second, auto reset on
		write_reg(CFG_TSEC, 32'hffffffff);
		write_reg(CFG_TNSEC, 32'hffffffff);
		write_reg(CFG_AUTO, 32'd1);
		send(mk(OP_START, '0, '0, '0, 2'd0));
		send(mk(OP_STOP, '1, '1, '0, 2'd0));
		send(mk(OP_DONE, '0, '0, '0, 2'd0));
		send(mk(OP_START, {32'd7, 32'd999999999}, 32'd1, '0, 2'd0));
		random_phase(RANDOM_ITEMS / 4);
		settle();

		// Random timeout in range
		write_reg(CFG_TSEC, $urandom);
		write_reg(CFG_TNSEC, 32'($urandom_range(999999999)));
		write_reg(CFG_AUTO, 32'($urandom_range(1)));
		random_phase(RANDOM_ITEMS / 4);
		settle();

		// Zero timeout, no auto reset, no idling on either side
		write_reg(CFG_TSEC, 32'd0);
		write_reg(CFG_TNSEC, 32'd0);
		write_reg(CFG_AUTO, 32'd0);
		steady = 1'b1;
		random_phase(RANDOM_ITEMS / 4);
		settle();
		steady = 1'b0;

		// Random timeout, nanoseconds anywhere in the register
		write_reg(CFG_TSEC, $urandom);
		write_reg(CFG_TNSEC, $urandom);
		write_reg(CFG_AUTO, 32'd1);
		random_phase(RANDOM_ITEMS / 4);
		settle();

		if (sb.mismatches == 0 && sb.predicted_outcomes.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/cwg_pkg.sv
rtl/core/cwg_front.sv
rtl/core/cwg_queue.sv
rtl/core/cwg_back.sv
rtl/core/count_window_gate.sv
verif/tb_count_window_gate.sv
